// ===== src/tetration_tower_mod_pow2_macros.svh =====
// Assertion macros for the tower block port checker.
`ifndef TETRATION_TOWER_MOD_POW2_MACROS_SVH
`define TETRATION_TOWER_MOD_POW2_MACROS_SVH

// Implication into the next cycle, switched off while reset is high.
`define TTMP_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("tower block check failed");

// Implication into the next cycle that is also checked during reset.
`define TTMP_ASSERT_NEXT_ALWAYS(label, clk, ante, cons) \
  label: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error("tower block check failed");

`endif

// ===== src/ttmp_pkg.sv =====
// Package: word types, widths and mask helper for the power tower block.
package ttmp_pkg;

  localparam int DATA_W     = 64;
  localparam int HALF_W     = DATA_W / 2;
  localparam int CFG_W      = 7;
  localparam int MAX_HEIGHT = 64;

  // Configuration register indexes
  localparam logic CFG_TOWER_HEIGHT = 1'b0;
  localparam logic CFG_MODULUS_BITS = 1'b1;

  typedef struct packed {
    logic [DATA_W-1:0] base_value;
    logic              last_in;
  } in_word_t;

  typedef struct packed {
    logic [DATA_W-1:0] tower_result;
    logic              last_out;
  } out_word_t;

  // Low w bits set, w from 0 to 64; a larger w gives all bits set
  function automatic logic [DATA_W-1:0] low_mask(input logic [CFG_W-1:0] w);
    logic [DATA_W-1:0] one;
    one = {{(DATA_W-1){1'b0}}, 1'b1};
    if (w >= CFG_W'(DATA_W)) begin
      low_mask = '1;
    end else begin
      low_mask = (one << w) - one;
    end
  endfunction

endpackage

// ===== src/tetration_tower_mod_pow2.sv =====
// Top level: power tower of a 64-bit base modulo a power of two, iterative.
//
// Use: an input word (base_value, last_in) is taken when in_valid is high and
// in_stall is low. The block then works alone on that word and holds in_stall
// high until the result has moved into the output register. A result word
// (tower_result, last_out) is offered with out_valid and taken when out_stall
// is low; a stalled result holds steady, and a new input word may be taken
// while it waits. Configuration (tower_height, modulus_bits) is written
// through cfg_we/cfg_index/cfg_data while the block is idle.
// Sequence: after the word is taken, each level passes a set-up step in
// S_LEVEL; a level above the bottom with a nonzero width then works through
// its exponent bits in S_BIT, and each product on the single shared 32x32
// multiplier runs through the phases LL, LH, HL and FIN (a 64-bit product
// mod 2^64 is three partial products). The exponent of level l has at most
// w(l-1) bits, w being the level width. The result is then handed over to
// the output register. Reset clears the configuration to height 1 and 64
// modulus bits and empties the output register.
module tetration_tower_mod_pow2 (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  ttmp_pkg::in_word_t          in_word,
  output logic                        out_valid,
  input  logic                        out_stall,
  output ttmp_pkg::out_word_t         out_word,
  input  logic                        cfg_we,
  input  logic                        cfg_index,
  input  logic [ttmp_pkg::CFG_W-1:0]  cfg_data
);
  import ttmp_pkg::*;

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_LEVEL = 3'd1;
  localparam logic [2:0] S_BIT   = 3'd2;
  localparam logic [2:0] S_MUL   = 3'd3;
  localparam logic [2:0] S_DONE  = 3'd4;

  localparam logic [1:0] PH_LL = 2'd0;
  localparam logic [1:0] PH_LH = 2'd1;
  localparam logic [1:0] PH_HL = 2'd2;
  localparam logic [1:0] PH_FIN = 2'd3;

  logic [2:0]        state;
  logic [CFG_W-1:0]  tower_height;
  logic [CFG_W-1:0]  modulus_bits;
  logic [CFG_W-1:0]  h_eff;
  logic [CFG_W-1:0]  mb_eff;
  logic [CFG_W-1:0]  lvl;
  logic [DATA_W-1:0] a;
  logic [DATA_W-1:0] v;
  logic [DATA_W-1:0] e;
  logic [DATA_W-1:0] acc;
  logic [DATA_W-1:0] b;
  logic [DATA_W-1:0] m;
  logic [DATA_W-1:0] res;
  logic [DATA_W-1:0] prod;
  logic [1:0]        mphase;
  logic              tgt_acc;
  logic              last_r;

  logic [CFG_W-1:0]  h_clamp;
  logic [CFG_W-1:0]  mb_clamp;
  logic [CFG_W-1:0]  k;
  logic signed [CFG_W+1:0] r;
  logic [CFG_W-1:0]  w_lvl;
  logic [DATA_W-1:0] mask_lvl;
  logic [DATA_W-1:0] mx;
  logic [HALF_W-1:0] mul_a;
  logic [HALF_W-1:0] mul_b;
  logic [HALF_W-1:0] hi_sum;
  logic [DATA_W-1:0] mul_res;

  // Saturate the configuration to its meaningful range
  always_comb begin
    h_clamp = tower_height;
    if (tower_height == '0) h_clamp = CFG_W'(1);
    if (tower_height > CFG_W'(MAX_HEIGHT)) h_clamp = CFG_W'(MAX_HEIGHT);
    mb_clamp = modulus_bits;
    if (modulus_bits == '0) mb_clamp = CFG_W'(1);
    if (modulus_bits > CFG_W'(DATA_W)) mb_clamp = CFG_W'(DATA_W);
  end

  // Width of the current level: mb - 2k while positive, then 1, then 0
  always_comb begin
    k = h_eff - lvl;
    r = $signed({2'b00, mb_eff}) - $signed({1'b0, k, 1'b0});
    if (r > 0) begin
      w_lvl = r[CFG_W-1:0];
    end else if (r == 0) begin
      w_lvl = CFG_W'(1);
    end else begin
      w_lvl = '0;
    end
    mask_lvl = low_mask(w_lvl);
  end

  // Shared multiplier operands, picked by product phase
  always_comb begin
    mx = tgt_acc ? acc : b;
    case (mphase)
      PH_LL: begin
        mul_a = mx[HALF_W-1:0];
        mul_b = b[HALF_W-1:0];
      end
      PH_LH: begin
        mul_a = mx[HALF_W-1:0];
        mul_b = b[DATA_W-1:HALF_W];
      end
      default: begin
        mul_a = mx[DATA_W-1:HALF_W];
        mul_b = b[HALF_W-1:0];
      end
    endcase
    hi_sum  = res[DATA_W-1:HALF_W] + prod[HALF_W-1:0];
    mul_res = {hi_sum, res[HALF_W-1:0]} & m;
  end

  assign in_stall = (state != S_IDLE);

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      tower_height <= CFG_W'(1);
      modulus_bits <= CFG_W'(DATA_W);
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_TOWER_HEIGHT: tower_height <= cfg_data;
        CFG_MODULUS_BITS: modulus_bits <= cfg_data;
        default: ;
      endcase
    end
  end

  // Product register of the shared 32x32 multiplier
  always_ff @(posedge clk) begin
    prod <= DATA_W'(mul_a) * DATA_W'(mul_b);
  end

  // Sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      if (out_valid && !out_stall && state != S_DONE) out_valid <= 1'b0;
      case (state)
        S_IDLE: begin
          if (in_valid) begin
            h_eff  <= h_clamp;
            mb_eff <= mb_clamp;
            a      <= in_word.base_value & low_mask(mb_clamp);
            last_r <= in_word.last_in;
            lvl    <= CFG_W'(1);
            state  <= S_LEVEL;
          end
        end
        S_LEVEL: begin
          if (lvl == CFG_W'(1) || w_lvl == '0) begin
            // bottom level or a zero width level closes at once
            v <= a & mask_lvl;
            if (lvl == h_eff) begin
              state <= S_DONE;
            end else begin
              lvl <= lvl + CFG_W'(1);
            end
          end else begin
            m     <= mask_lvl;
            e     <= v;
            acc   <= {{(DATA_W-1){1'b0}}, 1'b1};
            b     <= a & mask_lvl;
            state <= S_BIT;
          end
        end
        S_BIT: begin
          if (e == '0) begin
            v <= acc;
            if (lvl == h_eff) begin
              state <= S_DONE;
            end else begin
              lvl   <= lvl + CFG_W'(1);
              state <= S_LEVEL;
            end
          end else begin
            tgt_acc <= e[0];
            mphase  <= PH_LL;
            state   <= S_MUL;
          end
        end
        S_MUL: begin
          case (mphase)
            PH_LL: mphase <= PH_LH;
            PH_LH: begin
              res    <= prod;
              mphase <= PH_HL;
            end
            PH_HL: begin
              res[DATA_W-1:HALF_W] <= hi_sum;
              mphase <= PH_FIN;
            end
            default: begin
              if (tgt_acc) begin
                acc <= mul_res;
                if (e[DATA_W-1:1] == '0) begin
                  // last exponent bit: no further squaring
                  e     <= '0;
                  state <= S_BIT;
                end else begin
                  tgt_acc <= 1'b0;
                  mphase  <= PH_LL;
                end
              end else begin
                b     <= mul_res;
                e     <= e >> 1;
                state <= S_BIT;
              end
            end
          endcase
        end
        S_DONE: begin
          if (!out_valid || !out_stall) begin
            out_word.tower_result <= v;
            out_word.last_out     <= last_r;
            out_valid             <= 1'b1;
            state                 <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

// ===== src/ttmp_check.sv =====
// Port checker for the power tower block, bound to the top level.
`include "tetration_tower_mod_pow2_macros.svh"

module ttmp_check (
  input logic                clk,
  input logic                rst,
  input logic                in_valid,
  input logic                in_stall,
  input logic                out_valid,
  input logic                out_stall,
  input ttmp_pkg::out_word_t out_word
);
  import ttmp_pkg::*;

  // A waiting result word stays offered and steady
  `TTMP_ASSERT_NEXT(a_out_hold, clk, rst, out_valid && out_stall, out_valid)
  `TTMP_ASSERT_NEXT(a_out_stable, clk, rst, out_valid && out_stall, $stable(out_word))
  // Taking a word makes the block busy in the next cycle
  `TTMP_ASSERT_NEXT(a_busy_after_take, clk, rst, in_valid && !in_stall, in_stall)
  // Out of reset the block is idle and offers nothing
  `TTMP_ASSERT_NEXT_ALWAYS(a_reset_idle, clk, rst, !in_stall && !out_valid)

endmodule

bind tetration_tower_mod_pow2 ttmp_check u_ttmp_check (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (in_valid),
  .in_stall  (in_stall),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_word  (out_word)
);

// ===== tb/sv/tetration_tower_mod_pow2_tb.sv =====
// Self-checking testbench for the power tower modulo 2^mb block.
module tetration_tower_mod_pow2_tb;
  import ttmp_pkg::*;

  localparam int RESET_CYCLES = 7;
  localparam int STALL_LIMIT  = 60000;
  localparam int RANDOM_ITEMS = 265;
  localparam int TAIL_CYCLES  = 64;

  logic              clk;
  logic              rst;
  logic              in_valid;
  logic              in_stall;
  in_word_t          in_word;
  logic              out_valid;
  logic              out_stall;
  out_word_t         out_word;
  logic              cfg_we;
  logic              cfg_index;
  logic [CFG_W-1:0]  cfg_data;

  // Mirror of the configuration registers
  logic [CFG_W-1:0]  cur_height;
  logic [CFG_W-1:0]  cur_mbits;

  out_word_t         pending_towers[$];
  int unsigned       fault_count;
  int unsigned       quiet_cycles;
  bit                idle_on;

  tetration_tower_mod_pow2 dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_word   (in_word),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_word  (out_word),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  // Clock
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // ---------------------------------------------------------------- predictor

  function automatic logic [DATA_W-1:0] width_mask(input int w);
    if (w >= DATA_W) return '1;
    if (w <= 0) return '0;
    return (64'd1 << w) - 64'd1;
  endfunction

  // Exponent width for a modulus of 2^w
  function automatic int carmichael_width(input int w);
    if (w >= 3) return w - 2;
    if (w == 2) return 1;
    return 0;
  endfunction

  // b^e mod 2^w, square-and-multiply, products truncated to 64 bits
  function automatic logic [DATA_W-1:0] pow_mod2(input logic [DATA_W-1:0] b,
                                                 input logic [DATA_W-1:0] e,
                                                 input int w);
    logic [DATA_W-1:0] m;
    logic [DATA_W-1:0] acc;
    logic [DATA_W-1:0] sq;
    logic [DATA_W-1:0] ex;
    m   = width_mask(w);
    acc = 64'd1;
    sq  = b & m;
    ex  = e;
    while (ex != '0) begin
      if (ex[0]) acc = (acc * sq) & m;
      sq = (sq * sq) & m;
      ex = ex >> 1;
    end
    return acc & m;
  endfunction

  function automatic logic [DATA_W-1:0] tower_mod2(input logic [DATA_W-1:0] base,
                                                   input logic [CFG_W-1:0] h_reg,
                                                   input logic [CFG_W-1:0] mb_reg);
    int widths [0:MAX_HEIGHT];
    int h;
    int mb;
    int lvl;
    logic [DATA_W-1:0] a;
    logic [DATA_W-1:0] v;
    // saturate both registers into range
    h  = int'(h_reg);
    mb = int'(mb_reg);
    if (h < 1) h = 1;
    if (h > MAX_HEIGHT) h = MAX_HEIGHT;
    if (mb < 1) mb = 1;
    if (mb > DATA_W) mb = DATA_W;
    foreach (widths[i]) widths[i] = 0;
    widths[h] = mb;
    for (lvl = h; lvl > 1; lvl--) widths[lvl-1] = carmichael_width(widths[lvl]);
    a = base & width_mask(mb);
    if (h == 1) begin
      v = a;
    end else begin
      v = (widths[1] == 0) ? '0 : (a & width_mask(widths[1]));
      for (lvl = 2; lvl <= h; lvl++) begin
        if (widths[lvl] == 0) v = '0;
        else v = pow_mod2(a, v, widths[lvl]);
      end
    end
    return v;
  endfunction

  // ------------------------------------------------------------ monitors

  // Input side: predict on every accepted word
  always @(posedge clk) begin
    out_word_t exp_w;
    if (!rst && in_valid && in_stall === 1'b0) begin
      exp_w.tower_result = tower_mod2(in_word.base_value, cur_height, cur_mbits);
      exp_w.last_out     = in_word.last_in;
      pending_towers.push_back(exp_w);
    end
  end

  // Output side: compare against the oldest prediction
  always @(posedge clk) begin
    out_word_t exp_w;
    if (!rst && out_valid === 1'b1 && !out_stall) begin
      if (pending_towers.size() == 0) begin
        $error("unexpected result word: tower_result %h last_out %b",
               out_word.tower_result, out_word.last_out);
        fault_count++;
      end else begin
        exp_w = pending_towers.pop_front();
        if (out_word.tower_result !== exp_w.tower_result) begin
          $error("tower_result: expected %h, actual %h",
                 exp_w.tower_result, out_word.tower_result);
          fault_count++;
        end
        if (out_word.last_out !== exp_w.last_out) begin
          $error("last_out: expected %b, actual %b", exp_w.last_out, out_word.last_out);
          fault_count++;
        end
      end
    end
  end

  // Watchdog on cycles with no handshake on either side
  always @(posedge clk) begin
    if ((in_valid && in_stall === 1'b0) || (out_valid === 1'b1 && !out_stall)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("== FAIL ==");
        $finish;
      end
    end
  end

  // Result receiver: random stall before each word, none when idling is off
  initial begin
    int gap;
    out_stall = 1'b0;
    @(negedge clk);
    forever begin
      gap = idle_on ? $urandom_range(0, 6) : 0;
      repeat (gap) begin
        out_stall <= 1'b1;
        @(negedge clk);
      end
      out_stall <= 1'b0;
      do @(posedge clk); while (!(out_valid === 1'b1 && !out_stall));
      @(negedge clk);
    end
  end

  // ------------------------------------------------------------ drivers

  // Write both registers on consecutive cycles; block must be idle
  task automatic set_config(input logic [CFG_W-1:0] height, input logic [CFG_W-1:0] mbits);
    cfg_we    <= 1'b1;
    cfg_index <= CFG_TOWER_HEIGHT;
    cfg_data  <= height;
    cur_height = height;
    @(negedge clk);
    cfg_index <= CFG_MODULUS_BITS;
    cfg_data  <= mbits;
    cur_mbits  = mbits;
    @(negedge clk);
    cfg_we    <= 1'b0;
    @(negedge clk);
  endtask

  // Send one base word; called and returns at a falling edge
  task automatic send_base(input logic [DATA_W-1:0] base, input logic last);
    int gap;
    gap = idle_on ? $urandom_range(0, 6) : 0;
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid           <= 1'b1;
    in_word.base_value <= base;
    in_word.last_in    <= last;
    do @(posedge clk); while (in_stall !== 1'b0);
    @(negedge clk);
  endtask

  // Drop valid and wait until every predicted word has come back
  task automatic finish_phase();
    in_valid <= 1'b0;
    @(negedge clk);
    while (pending_towers.size() != 0) @(negedge clk);
  endtask

  function automatic logic [DATA_W-1:0] random_base();
    case ($urandom_range(0, 7))
      0: return '0;
      1: return '1;
      2: return 64'($urandom_range(0, 15));
      3: return {$urandom, $urandom} | 64'd1;
      4: return {$urandom, $urandom} & ~64'd1;
      default: return {$urandom, $urandom};
    endcase
  endfunction

  // ------------------------------------------------------------ tests

  // Reset values: height 1, 64 bits, so the base comes straight back
  task automatic test_reset_defaults();
    idle_on = 1'b1;
    send_base('0, 1'b0);
    send_base('1, 1'b0);
    send_base(64'h8000_0000_0000_0001, 1'b0);
    send_base(64'h5555_AAAA_3333_CCCC, 1'b1);
    finish_phase();
  endtask

  // Tallest tower at full width, and a short one, back to back
  task automatic test_full_extremes();
    idle_on = 1'b0;
    set_config(7'd64, 7'd64);
    send_base('1, 1'b0);
    send_base(64'd3, 1'b0);
    send_base(64'd2, 1'b1);
    finish_phase();
    idle_on = 1'b1;
    set_config(7'd2, 7'd64);
    send_base('1, 1'b1);
    send_base(64'hFFFF_FFFF_0000_0003, 1'b0);
    send_base('0, 1'b1);
    finish_phase();
  endtask

  // Register values outside 1..64 saturate
  task automatic test_saturation();
    idle_on = 1'b1;
    set_config(7'd0, 7'd0);
    send_base('1, 1'b1);
    send_base(64'd2, 1'b0);
    finish_phase();
    set_config(7'd127, 7'd127);
    send_base(64'd5, 1'b1);
    finish_phase();
    set_config(7'd65, 7'd65);
    send_base(64'hDEAD_BEEF_0123_4567, 1'b0);
    finish_phase();
  endtask

  // Narrow moduli where the chain reaches zero-width levels
  task automatic test_narrow_levels();
    idle_on = 1'b1;
    set_config(7'd3, 7'd2);
    send_base(64'd3, 1'b0);
    send_base(64'd6, 1'b1);
    finish_phase();
    set_config(7'd2, 7'd1);
    send_base(64'd4, 1'b1);
    finish_phase();
    set_config(7'd4, 7'd3);
    send_base(64'd7, 1'b0);
    send_base(64'hF0, 1'b1);
    finish_phase();
    set_config(7'd1, 7'd1);
    send_base('1, 1'b1);
    finish_phase();
  endtask

  // Random batches under random settings; wide moduli kept rare (slow)
  task automatic test_random_batches();
    int sent;
    int n;
    int kind;
    logic [CFG_W-1:0] h;
    logic [CFG_W-1:0] mb;
    sent = 0;
    while (sent < RANDOM_ITEMS) begin
      kind = $urandom_range(0, 15);
      if (kind < 2) begin
        h  = CFG_W'($urandom_range(1, 64));
        mb = CFG_W'($urandom_range(33, 64));
        n  = $urandom_range(2, 5);
      end else if (kind == 2) begin
        h  = ($urandom_range(0, 1) == 0) ? 7'd0 : CFG_W'($urandom_range(65, 127));
        mb = ($urandom_range(0, 1) == 0) ? 7'd0 : CFG_W'($urandom_range(65, 127));
        n  = $urandom_range(2, 4);
      end else begin
        h  = ($urandom_range(0, 3) == 0) ? CFG_W'($urandom_range(1, 64))
                                         : CFG_W'($urandom_range(1, 6));
        mb = CFG_W'($urandom_range(1, 20));
        n  = $urandom_range(6, 16);
      end
      idle_on = ($urandom_range(0, 3) != 0);
      set_config(h, mb);
      for (int i = 0; i < n; i++) begin
        // batch ends on the last word, with the odd early marker
        send_base(random_base(), (i == n - 1) || ($urandom_range(0, 7) == 0));
      end
      finish_phase();
      sent += n;
    end
  endtask

  // ------------------------------------------------------------ sequence

  initial begin
    clk          = 1'b0;
    rst          = 1'b1;
    in_valid     = 1'b0;
    in_word      = '0;
    cfg_we       = 1'b0;
    cfg_index    = CFG_TOWER_HEIGHT;
    cfg_data     = '0;
    cur_height   = 7'd1;
    cur_mbits    = 7'd64;
    fault_count  = 0;
    quiet_cycles = 0;
    idle_on      = 1'b1;
    repeat (RESET_CYCLES) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    test_reset_defaults();
    test_full_extremes();
    test_saturation();
    test_narrow_levels();
    test_random_batches();

    // catch any stray word after the last one
    repeat (TAIL_CYCLES) @(negedge clk);
    if (fault_count == 0 && pending_towers.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
+incdir+src
src/ttmp_pkg.sv
src/tetration_tower_mod_pow2.sv
src/ttmp_check.sv
tb/sv/tetration_tower_mod_pow2_tb.sv
